FILE: design/gwm_pkg.sv
// Package for the glob wildcard matcher: character codes, register indexes,
// the case fold function and the per-cell status record.
// No dependencies; every other file of the block imports it.
package gwm_pkg;

  localparam int CHAR_W        = 8;
  localparam int WORD_W        = 64;
  localparam int PATTERN_WORDS = 6;
  localparam int PATTERN_BYTES = PATTERN_WORDS * (WORD_W / CHAR_W);
  localparam int LEN_REG_W     = 6;
  localparam int CFG_INDEX_W   = 3;

  typedef logic [CHAR_W-1:0]      char_t;
  typedef logic [WORD_W-1:0]      word_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  // Register indexes; pattern words occupy indexes 0 to PATTERN_WORDS-1.
  localparam cfg_index_t REG_PATTERN_LEN    = cfg_index_t'(PATTERN_WORDS);
  localparam cfg_index_t REG_CASE_SENSITIVE = cfg_index_t'(PATTERN_WORDS + 1);

  // Pattern codes.
  localparam char_t CH_ANY   = 8'h3F;  // '?'
  localparam char_t CH_RUN   = 8'h2A;  // '*'
  localparam char_t PAD_BYTE = 8'h00;  // bytes past the stored pattern

  localparam char_t LOWER_A    = 8'h61;
  localparam char_t LOWER_Z    = 8'h7A;
  localparam char_t CASE_DELTA = 8'h20;

  typedef struct packed {
    logic cur;      // active bit seen by this step
    logic star;     // position holds a star inside the pattern
    logic keep;     // star keeps this position active
    logic advance;  // character consumed, next position becomes active
  } cell_out_t;

  // Folds ASCII lower case letters to upper case unless compare is exact.
  function automatic char_t fold_char(input char_t c, input logic exact);
    char_t r;
    r = c;
    if (!exact && (c >= LOWER_A) && (c <= LOWER_Z)) begin
      r = c - CASE_DELTA;
    end
    return r;
  endfunction

endpackage

FILE: design/gwm_if.sv
// Handshake interfaces of the glob wildcard matcher: text requests in,
// match results out. Depends on gwm_pkg.
interface gwm_text_if import gwm_pkg::*; ();
  logic  valid;
  logic  ready;
  char_t text_char;
  logic  last_char;
  logic  empty_string;

  modport source (output valid, output text_char, output last_char,
                  output empty_string, input ready);
  modport sink   (input valid, input text_char, input last_char,
                  input empty_string, output ready);
endinterface

interface gwm_result_if import gwm_pkg::*; ();
  logic valid;
  logic ready;
  logic matched;

  modport source (output valid, output matched, input ready);
  modport sink   (input valid, input matched, output ready);
endinterface

FILE: design/gwm_cell.sv
// One pattern position of the matcher: holds its active bit and compares
// its pattern byte against the current character. Depends on gwm_pkg.
module gwm_cell import gwm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      enable,
  input  char_t     pat_char,
  input  char_t     text_char,
  input  logic      fresh,
  input  logic      start_bit,
  input  logic      load,
  input  logic      closed_bit,
  output cell_out_t status
);

  logic active;
  logic cur;
  logic star;

  // A fresh string starts from the closure of position zero.
  assign cur  = fresh ? start_bit : active;
  assign star = enable && (pat_char == CH_RUN);

  always_comb begin
    status.cur     = cur;
    status.star    = star;
    status.keep    = cur && star;
    status.advance = cur && enable && !star &&
                     ((pat_char == CH_ANY) || (pat_char == text_char));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (load) begin
      active <= closed_bit;
    end
  end

endmodule

FILE: design/gwm_closure.sv
// Star closure over the position vector: an active star position also
// activates the one after it, across whole runs of stars. Parallel prefix
// in log2 levels. Depends on gwm_pkg.
module gwm_closure import gwm_pkg::*; #(
  parameter int WIDTH = 49
) (
  input  logic [WIDTH-1:0] raw,
  input  logic [WIDTH-1:0] star,
  output logic [WIDTH-1:0] closed
);

  localparam int LEVELS = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic [WIDTH-1:0] g [LEVELS+1];
  logic [WIDTH-1:0] p [LEVELS+1];

  always_comb begin
    g[0] = raw;
    // Position i is reachable from i-1 when i-1 holds a star.
    p[0] = {star[WIDTH-2:0], 1'b0};
    for (int l = 0; l < LEVELS; l++) begin
      for (int i = 0; i < WIDTH; i++) begin
        if (i >= (1 << l)) begin
          g[l+1][i] = g[l][i] | (p[l][i] & g[l][i-(1<<l)]);
          p[l+1][i] = p[l][i] & p[l][i-(1<<l)];
        end else begin
          g[l+1][i] = g[l][i];
          p[l+1][i] = p[l][i];
        end
      end
    end
    closed = g[LEVELS];
  end

endmodule

FILE: design/glob_wildcard_matcher.sv
// Top level of the glob wildcard matcher: configuration registers, the row
// of position cells, star closure and the result register.
// Depends on gwm_pkg, gwm_if, gwm_cell and gwm_closure.
//
//  Port        Direction  Carries
//  text        sink       text_char, last_char, empty_string
//  result      source     matched (one per string)
//  cfg_*       input      write enable, register index, 64-bit data
//
// A new request can be accepted in each cycle while the text side is not stalled.
// The position vector is advanced by all cells at once and closed over
// star runs by a logarithmic prefix network in the same cycle.
// A result sits in one output register; the text side stalls only while
// that register is full and not being taken.
// Reset is synchronous; it clears the pattern, the length and the flag
// and restarts the string; a configuration write also restarts it.
module glob_wildcard_matcher import gwm_pkg::*; #(
  parameter int PATTERN_MAX = 48
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  cfg_index_t          cfg_index,
  input  word_t               cfg_data,
  gwm_text_if.sink            text,
  gwm_result_if.source        result
);

  localparam int NPOS  = PATTERN_MAX + 1;
  localparam int POS_W = $clog2(NPOS);

  word_t                pattern_word [PATTERN_WORDS];
  logic [LEN_REG_W-1:0] pattern_len;
  logic                 case_sensitive;

  // The vector in the cells is valid only when fresh is low; while fresh
  // is high every cell sees the closure of position zero instead.
  logic fresh;

  logic [POS_W-1:0] eff_len;
  logic [LEN_REG_W:0] len_wide;
  logic [NPOS-1:0]  enable;
  logic [NPOS-1:0]  star_vec;
  logic [NPOS-1:0]  cur_vec;
  logic [NPOS-1:0]  raw_vec;
  logic [NPOS-1:0]  closed_vec;
  logic [NPOS-1:0]  start_vec;
  logic [NPOS-1:0]  seed_vec;
  logic [NPOS-1:0]  allowed;
  cell_out_t        cell_st [NPOS];
  char_t            text_fold;
  logic             accept;
  logic             ends_string;
  logic             step;
  logic             out_valid;
  logic             out_matched;

  // Lengths beyond the row saturate to the row size.
  assign len_wide = {1'b0, pattern_len};
  assign eff_len  = (len_wide > (LEN_REG_W+1)'(PATTERN_MAX)) ?
                    POS_W'(PATTERN_MAX) : POS_W'(len_wide);

  assign text_fold   = fold_char(text.text_char, case_sensitive);
  assign accept      = text.valid && text.ready;
  assign ends_string = text.last_char || text.empty_string;
  assign step        = accept && !ends_string;

  // The output register frees up in the same cycle it is taken.
  assign text.ready = !out_valid || result.ready;

  assign seed_vec = NPOS'(1);

  genvar gi;
  generate
    for (gi = 0; gi < NPOS; gi++) begin : g_pos
      char_t pat_raw;
      if (gi < PATTERN_BYTES) begin : g_stored
        assign pat_raw = pattern_word[gi / 8][(gi % 8) * CHAR_W +: CHAR_W];
      end else begin : g_pad
        assign pat_raw = PAD_BYTE;
      end

      assign enable[gi]  = eff_len > POS_W'(gi);
      assign allowed[gi] = eff_len >= POS_W'(gi);

      gwm_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .enable     (enable[gi]),
        .pat_char   (fold_char(pat_raw, case_sensitive)),
        .text_char  (text_fold),
        .fresh      (fresh),
        .start_bit  (start_vec[gi]),
        .load       (step),
        .closed_bit (closed_vec[gi]),
        .status     (cell_st[gi])
      );

      assign star_vec[gi] = cell_st[gi].star;
      assign cur_vec[gi]  = cell_st[gi].cur;

      // A position stays active through its own star or is reached by the
      // character consumed in the cell before it.
      if (gi == 0) begin : g_first
        assign raw_vec[gi] = cell_st[gi].keep;
      end else begin : g_rest
        assign raw_vec[gi] = cell_st[gi].keep | cell_st[gi-1].advance;
      end
    end
  endgenerate

  // Starting set of a new string under the present configuration.
  gwm_closure #(.WIDTH(NPOS)) u_start (
    .raw    (seed_vec),
    .star   (star_vec),
    .closed (start_vec)
  );

  // Set after the current character.
  gwm_closure #(.WIDTH(NPOS)) u_step (
    .raw    (raw_vec),
    .star   (star_vec),
    .closed (closed_vec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < PATTERN_WORDS; w++) begin
        pattern_word[w] <= '0;
      end
      pattern_len    <= '0;
      case_sensitive <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PATTERN_LEN:    pattern_len    <= cfg_data[LEN_REG_W-1:0];
        REG_CASE_SENSITIVE: case_sensitive <= cfg_data[0];
        default:            pattern_word[cfg_index] <= cfg_data;
      endcase
    end
  end

  // A string restarts after reset, after any register write and after the
  // request that ends it.
  always_ff @(posedge clk) begin
    if (rst) begin
      fresh <= 1'b1;
    end else if (cfg_write) begin
      fresh <= 1'b1;
    end else if (accept) begin
      fresh <= ends_string;
    end
  end

  // An empty string is judged on the starting set alone; a last character
  // on the set after that character.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && ends_string) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && ends_string) begin
      out_matched <= text.empty_string ? start_vec[eff_len] : closed_vec[eff_len];
    end
  end

  assign result.valid   = out_valid;
  assign result.matched = out_matched;

  // Any register write forces the next request onto a fresh string.
  a_cfg_restarts: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> fresh)
    else $error("configuration write did not restart the string");

  // A string that is under way never holds positions past the pattern end.
  a_no_stray_bits: assert property (@(posedge clk) disable iff (rst)
    !fresh |-> ((cur_vec & ~allowed) == '0))
    else $error("active position beyond the pattern length");

  // A request that ends a string always leaves a result behind.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (accept && ends_string) |=> out_valid)
    else $error("string end gave no result");

endmodule

FILE: test/glob_wildcard_matcher_test.sv
// Self-checking testbench for glob_wildcard_matcher: a directed table, then
// random patterns and strings checked against a bit-exact glob predictor.
// Depends on gwm_pkg, gwm_if and the matcher RTL.
module glob_wildcard_matcher_test import gwm_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1150;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int SETTLE       = 4;

  // One bit per pattern position, position PATTERN_BYTES being "all consumed".
  typedef logic [PATTERN_BYTES:0] posvec_t;

  typedef enum logic [1:0] {ROW_WRITE, ROW_ITEM} row_kind_t;

  // A row of the directed table. want is -1 when the predictor decides the
  // expected match, otherwise the match value read straight off the case.
  typedef struct {
    row_kind_t  kind;
    cfg_index_t index;
    word_t      data;
    char_t      ch;
    logic       last;
    logic       empty;
    int         want;
  } stim_row_t;

  logic       clk;
  logic       rst;
  logic       cfg_write;
  cfg_index_t cfg_index;
  word_t      cfg_data;

  gwm_text_if   text_bus ();
  gwm_result_if result_bus ();

  glob_wildcard_matcher uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .text      (text_bus),
    .result    (result_bus)
  );

  // Predictor state: its own copy of the registers and the active set.
  word_t     pat_word [PATTERN_WORDS];
  logic [LEN_REG_W-1:0] pat_len;
  logic      exact;
  posvec_t   live;

  // Match flags still owed by the block, oldest first.
  logic      pending_matches [$];

  char_t     text_buf [$];
  stim_row_t plan [$];

  int        errors = 0;
  int        cycle_count = 0;
  int        items_sent;
  bit        tx_idle_on;
  bit        rx_stall_on;
  int        stall_left = 0;
  logic      want_match;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The run ends here if the block hangs or results never come back.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    errors++;
  endtask

  // ---------------------------------------------------------------------
  // Glob predictor
  // ---------------------------------------------------------------------

  function automatic char_t fold_text(input char_t c);
    char_t r;
    r = c;
    if (!exact && c >= LOWER_A && c <= LOWER_Z) begin
      r = c - CASE_DELTA;
    end
    return r;
  endfunction

  function automatic char_t raw_byte(input int k);
    return pat_word[k / 8][(k % 8) * 8 +: 8];
  endfunction

  // Pattern bytes past the stored words read as zero; in practice the
  // length is clamped first, so this only guards the index.
  function automatic char_t pat_at(input int k);
    if (k >= PATTERN_BYTES) begin
      return fold_text(PAD_BYTE);
    end
    return fold_text(raw_byte(k));
  endfunction

  // A length register above the pattern size behaves as the full size.
  function automatic int eff_len();
    int n;
    n = pat_len;
    if (n > PATTERN_BYTES) begin
      n = PATTERN_BYTES;
    end
    return n;
  endfunction

  // Walking upward lets a run of stars propagate in a single pass.
  function automatic posvec_t star_close(input posvec_t v);
    posvec_t r;
    int      n;
    r = v;
    n = eff_len();
    for (int i = 0; i < n; i++) begin
      if (r[i] && pat_at(i) == CH_RUN) begin
        r[i + 1] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic posvec_t start_set();
    posvec_t v;
    v    = '0;
    v[0] = 1'b1;
    return star_close(v);
  endfunction

  // Advances the active set by one request and tells whether the request
  // ends a string, and if so whether the string matched.
  task automatic glob_step(input char_t c, input logic last, input logic empty,
                           output logic has_res, output logic m);
    posvec_t nxt;
    char_t   cf;
    char_t   p;
    int      n;
    n       = eff_len();
    cf      = fold_text(c);
    has_res = 1'b0;
    m       = 1'b0;
    if (empty) begin
      // An empty string throws away any partial string in flight.
      live    = start_set();
      has_res = 1'b1;
      m       = live[n];
      return;
    end
    nxt = '0;
    for (int i = 0; i < n; i++) begin
      if (live[i]) begin
        p = pat_at(i);
        if (p == CH_RUN) begin
          nxt[i] = 1'b1;
        end else if (p == CH_ANY || p == cf) begin
          nxt[i + 1] = 1'b1;
        end
      end
    end
    nxt = star_close(nxt);
    if (last) begin
      has_res = 1'b1;
      m       = nxt[n];
      live    = start_set();
    end else begin
      live = nxt;
    end
  endtask

  // ---------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------

  // Mostly back-to-back, a fair share of short gaps and a rare long one.
  function automatic int idle_cycles(input bit enabled);
    int r;
    if (!enabled) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(15, 40);
  endfunction

  // A register write lands at the next edge; the predictor follows it there.
  // The enable is dropped after that edge and the task returns at a later one,
  // so back-to-back calls never assign it twice in one step.
  task automatic cfg_put(input cfg_index_t idx, input word_t data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (idx < cfg_index_t'(PATTERN_WORDS)) begin
      pat_word[idx] = data;
    end else if (idx == REG_PATTERN_LEN) begin
      pat_len = data[LEN_REG_W-1:0];
    end else if (idx == REG_CASE_SENSITIVE) begin
      exact = data[0];
    end
    live = start_set();
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Holds off the text side until every owed match has come back, then
  // waits a settling time for a request that is still inside the block.
  task automatic drain();
    text_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_matches.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  // Offers one request and waits for its handshake. A nonnegative want
  // overrides the predicted match with a value typed into the table.
  task automatic send_item(input char_t c, input logic last, input logic empty,
                           input int want);
    int   gap;
    logic has_res;
    logic m;
    gap = idle_cycles(tx_idle_on);
    if (gap > 0) begin
      text_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_bus.valid        <= 1'b1;
    text_bus.text_char    <= c;
    text_bus.last_char    <= last;
    text_bus.empty_string <= empty;
    @(posedge clk);
    while (!text_bus.ready) begin
      @(posedge clk);
    end
    glob_step(c, last, empty, has_res, m);
    if (has_res) begin
      pending_matches.push_back(want < 0 ? m : want[0]);
    end
    items_sent++;
  endtask

  // ---------------------------------------------------------------------
  // Random content
  // ---------------------------------------------------------------------

  // A small alphabet so that literals meet often, with both cases, the two
  // wildcard codes as plain text, zero bytes and now and then any byte.
  function automatic char_t pick_char();
    case ($urandom_range(0, 9))
      0: return "a";
      1: return "b";
      2: return "A";
      3: return "B";
      4: return CH_ANY;
      5: return CH_RUN;
      6: return 8'h00;
      default: return char_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic char_t pick_pattern_char();
    int r;
    r = $urandom_range(0, 7);
    if (r < 2) begin
      return CH_RUN;
    end
    if (r == 2) begin
      return CH_ANY;
    end
    return pick_char();
  endfunction

  // Writes a fresh pattern, length and case flag. Lengths are mostly short;
  // bytes past the length are random so every data bit gets exercised.
  task automatic load_pattern();
    char_t bytes [PATTERN_BYTES];
    int    len_val;
    int    r;
    int    start;
    int    idx;
    word_t w;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      len_val = $urandom_range(0, 8);
    end else if (r < 95) begin
      len_val = $urandom_range(9, PATTERN_BYTES);
    end else begin
      len_val = $urandom_range(PATTERN_BYTES + 1, (1 << LEN_REG_W) - 1);
    end
    for (int k = 0; k < PATTERN_BYTES; k++) begin
      bytes[k] = (k < len_val) ? pick_pattern_char() : char_t'($urandom_range(0, 255));
    end
    // Register order is rotated so writes land in varied sequences.
    start = $urandom_range(0, PATTERN_WORDS + 1);
    for (int k = 0; k < PATTERN_WORDS + 2; k++) begin
      idx = (k + start) % (PATTERN_WORDS + 2);
      w   = {$urandom, $urandom};
      if (idx < PATTERN_WORDS) begin
        for (int b = 0; b < 8; b++) begin
          w[b * 8 +: 8] = bytes[idx * 8 + b];
        end
      end else if (cfg_index_t'(idx) == REG_PATTERN_LEN) begin
        w[LEN_REG_W-1:0] = len_val[LEN_REG_W-1:0];
      end
      cfg_put(cfg_index_t'(idx), w);
    end
  endtask

  // Builds a string that mostly follows the pattern, sometimes with one
  // edit, and sometimes no relation to it at all.
  task automatic make_text();
    char_t b;
    int    pos;
    int    n;
    text_buf.delete();
    n = eff_len();
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(0, 6)) text_buf.push_back(pick_char());
      return;
    end
    for (int k = 0; k < n; k++) begin
      b = raw_byte(k);
      if (b == CH_RUN) begin
        repeat ($urandom_range(0, 2)) text_buf.push_back(pick_char());
      end else if (b == CH_ANY) begin
        text_buf.push_back(pick_char());
      end else if ((b | CASE_DELTA) >= LOWER_A && (b | CASE_DELTA) <= LOWER_Z &&
                   $urandom_range(0, 3) == 0) begin
        text_buf.push_back(b ^ CASE_DELTA);
      end else begin
        text_buf.push_back(b);
      end
    end
    if ($urandom_range(0, 9) < 3 && text_buf.size() > 0) begin
      pos = $urandom_range(0, text_buf.size() - 1);
      case ($urandom_range(0, 2))
        0: text_buf[pos] = pick_char();
        1: text_buf.delete(pos);
        default: text_buf.insert(pos, pick_char());
      endcase
    end
  endtask

  task automatic send_string();
    if (text_buf.size() == 0) begin
      send_item(char_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1, -1);
    end else begin
      for (int i = 0; i < text_buf.size(); i++) begin
        send_item(text_buf[i], i == text_buf.size() - 1, 1'b0, -1);
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Result side: checks every accepted match and stalls at random.
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (pending_matches.size() == 0) begin
        report_mismatch($sformatf("match %0b with no string pending",
                                  result_bus.matched));
      end else begin
        want_match = pending_matches.pop_front();
        if (result_bus.matched !== want_match) begin
          report_mismatch($sformatf("matched %0b, expected %0b",
                                    result_bus.matched, want_match));
        end
      end
    end
    if (stall_left > 0) begin
      result_bus.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      result_bus.ready <= 1'b1;
      stall_left <= idle_cycles(rx_stall_on);
    end
  end

  // ---------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------

  function automatic stim_row_t row_wr(input cfg_index_t idx, input word_t data);
    stim_row_t r;
    r       = '{kind: ROW_WRITE, default: '0};
    r.index = idx;
    r.data  = data;
    r.want  = -1;
    return r;
  endfunction

  function automatic stim_row_t row_item(input char_t c, input logic last,
                                         input logic empty, input int want);
    stim_row_t r;
    r       = '{kind: ROW_ITEM, default: '0};
    r.ch    = c;
    r.last  = last;
    r.empty = empty;
    r.want  = want;
    return r;
  endfunction

  task automatic build_plan();
    // Straight after reset the pattern is empty: only an empty string matches.
    plan.push_back(row_item(8'h00, 1'b0, 1'b1, 1));
    plan.push_back(row_item("a", 1'b1, 1'b0, 0));
    // "a?c*" with case folding: letters of either case, one wildcard slot and
    // a trailing run; then a string dropped half way by an empty request.
    plan.push_back(row_wr(cfg_index_t'(0), 64'h0000_0000_2A63_3F61));
    plan.push_back(row_wr(REG_PATTERN_LEN, word_t'(4)));
    plan.push_back(row_item("A", 1'b0, 1'b0, -1));
    plan.push_back(row_item("b", 1'b0, 1'b0, -1));
    plan.push_back(row_item("C", 1'b1, 1'b0, -1));
    plan.push_back(row_item("a", 1'b0, 1'b0, -1));
    plan.push_back(row_item("x", 1'b0, 1'b0, -1));
    plan.push_back(row_item("d", 1'b1, 1'b0, -1));
    plan.push_back(row_item("a", 1'b0, 1'b0, -1));
    plan.push_back(row_item("?", 1'b0, 1'b0, -1));
    plan.push_back(row_item("z", 1'b1, 1'b1, -1));
    // Exact compare: an upper case text letter no longer meets a lower one.
    plan.push_back(row_wr(REG_CASE_SENSITIVE, word_t'(1)));
    plan.push_back(row_item("A", 1'b0, 1'b0, -1));
    plan.push_back(row_item("b", 1'b0, 1'b0, -1));
    plan.push_back(row_item("c", 1'b1, 1'b0, -1));
    // A full pattern of stars with the length register at its maximum, which
    // clamps to the pattern size.
    for (int k = 0; k < PATTERN_WORDS; k++) begin
      plan.push_back(row_wr(cfg_index_t'(k), 64'h2A2A_2A2A_2A2A_2A2A));
    end
    plan.push_back(row_wr(REG_PATTERN_LEN, word_t'((1 << LEN_REG_W) - 1)));
    plan.push_back(row_item(8'h00, 1'b1, 1'b1, 1));
    plan.push_back(row_item(8'hFF, 1'b1, 1'b0, 1));
    // The last pattern byte becomes a literal, so only the clamped length
    // reaches it.
    plan.push_back(row_wr(cfg_index_t'(PATTERN_WORDS - 1), 64'h7A2A_2A2A_2A2A_2A2A));
    plan.push_back(row_item("z", 1'b1, 1'b0, -1));
    plan.push_back(row_item("Z", 1'b1, 1'b0, -1));
    // All-ones data: a single 0xFF literal.
    plan.push_back(row_wr(cfg_index_t'(0), '1));
    plan.push_back(row_wr(REG_PATTERN_LEN, word_t'(1)));
    plan.push_back(row_item(8'hFF, 1'b1, 1'b0, 1));
    plan.push_back(row_item(8'h00, 1'b1, 1'b0, 0));
    // Zero bytes are literals, not terminators.
    plan.push_back(row_wr(cfg_index_t'(0), '0));
    plan.push_back(row_wr(REG_PATTERN_LEN, word_t'(2)));
    plan.push_back(row_item(8'h00, 1'b0, 1'b0, -1));
    plan.push_back(row_item(8'h00, 1'b1, 1'b0, -1));
    // Back to folding and an empty pattern.
    plan.push_back(row_wr(REG_CASE_SENSITIVE, '0));
    plan.push_back(row_wr(REG_PATTERN_LEN, '0));
    plan.push_back(row_item("q", 1'b0, 1'b0, -1));
    plan.push_back(row_item(8'h80, 1'b0, 1'b1, 1));
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------

  initial begin
    int target;
    int phase_end;
    rst                     = 1'b1;
    cfg_write               = 1'b0;
    cfg_index               = '0;
    cfg_data                = '0;
    text_bus.valid          = 1'b0;
    text_bus.text_char      = '0;
    text_bus.last_char      = 1'b0;
    text_bus.empty_string   = 1'b0;
    items_sent              = 0;
    tx_idle_on              = 1'b1;
    rx_stall_on             = 1'b1;

    // The predictor starts from the cleared registers that reset gives.
    for (int k = 0; k < PATTERN_WORDS; k++) begin
      pat_word[k] = '0;
    end
    pat_len = '0;
    exact   = 1'b0;
    live    = start_set();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    build_plan();
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        drain();
        cfg_put(plan[i].index, plan[i].data);
      end else begin
        send_item(plan[i].ch, plan[i].last, plan[i].empty, plan[i].want);
      end
    end

    // Random phases: each one loads a new configuration on an idle block,
    // picks whether either side idles, and streams strings against it.
    // The drain before each load is also the point where the sender waits
    // for every owed match.
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      drain();
      load_pattern();
      tx_idle_on  = $urandom_range(0, 3) != 0;
      rx_stall_on = $urandom_range(0, 3) != 0;
      phase_end   = items_sent + $urandom_range(40, 160);
      while (items_sent < phase_end && items_sent < target) begin
        if ($urandom_range(0, 11) == 0) begin
          // A few characters, then an empty string that drops them.
          repeat ($urandom_range(1, 3)) send_item(pick_char(), 1'b0, 1'b0, -1);
          send_item(pick_char(), 1'($urandom_range(0, 1)), 1'b1, -1);
        end else begin
          make_text();
          send_string();
        end
      end
      // Leave a partial string behind for the next register write to drop.
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 3)) send_item(pick_char(), 1'b0, 1'b0, -1);
      end
    end

    drain();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
